### rtl/assert_macros.svh
// Assertion macros for the RTL files that check their own logic.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/dhoat_pkg.sv
// Shared types, codes and defaults for the double-hash open-address table.
// No dependencies.
package dhoat_pkg;

    localparam int TABLE_SIZE_DEF = 251;
    localparam int KEY_BITS_DEF   = 32;
    localparam int VALUE_BITS_DEF = 32;

    localparam int ACTION_W = 2;
    localparam int STATUS_W = 2;
    localparam int FOUND_W  = 32;
    localparam int COUNT_W  = 8;

    typedef logic [ACTION_W-1:0] action_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam action_t ACT_INSERT = 2'd0;
    localparam action_t ACT_SEARCH = 2'd1;
    localparam action_t ACT_DELETE = 2'd2;

    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_NOT_FOUND = 2'd1;
    localparam status_t ST_DUPLICATE = 2'd2;
    localparam status_t ST_FULL      = 2'd3;

    // controller -> datapath
    typedef struct packed {
        logic    load;        // capture item, restart hash
        logic    hash_step;   // consume one key digit
        logic    probe_init;  // first slot and step from hash residues
        logic    rd;          // read slot at probe position
        logic    probe_next;  // advance probe position
        logic    note_target; // remember probe position as insert slot
        logic    wr_insert;   // write live entry at insert slot
        logic    wr_delete;   // turn slot at probe position into tombstone
        logic    clr_step;    // clear one slot after reset
        logic    res_load;    // load output register
        status_t res_status;
        logic    res_found;   // return read value
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic    hash_done;
        action_t action;
        logic    full;
        logic    occ;
        logic    tomb;
        logic    match;
        logic    last_probe;
        logic    have_target;
        logic    clr_last;
        logic    out_free;
    } sts_t;

endpackage

### rtl/dhoat_hash.sv
// Radix-16 residue unit: key mod MODULUS, one hex digit per cycle while step is high.
// Depends on nothing but its parameters.
module dhoat_hash #(
    parameter int MODULUS = 251,
    parameter int RES_W   = 8
) (
    input  logic             clk,
    input  logic             clear,
    input  logic             step,
    input  logic [3:0]       digit,
    output logic [RES_W-1:0] residue
);
    localparam int XW = RES_W + 4;

    logic [RES_W-1:0] res_reg;
    logic [RES_W-1:0] res_next;
    logic [XW-1:0]    shifted;
    logic [XW-1:0]    sub;

    // res < M, so shifted < 16M: pick the largest k*M not above it
    always_comb
    begin
        shifted = {res_reg, digit};
        sub     = '0;
        for (int k = 1; k < 16; k++)
        begin
            if (shifted >= XW'(k * MODULUS))
            begin
                sub = XW'(k * MODULUS);
            end
        end
        res_next = RES_W'(shifted - sub);
    end

    always_ff @(posedge clk)
    begin
        if (clear)
        begin
            res_reg <= '0;
        end
        else if (step)
        begin
            res_reg <= res_next;
        end
    end

    assign residue = res_reg;

endmodule

### rtl/dhoat_dp.sv
// Datapath: item registers, hash units, probe position, slot memory,
// live counter and output register. Depends on dhoat_pkg and dhoat_hash.
module dhoat_dp #(
    parameter int TABLE_SIZE = dhoat_pkg::TABLE_SIZE_DEF,
    parameter int KEY_BITS   = dhoat_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = dhoat_pkg::VALUE_BITS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  dhoat_pkg::cmd_t                cmd,
    output dhoat_pkg::sts_t                sts,
    input  dhoat_pkg::action_t             action,
    input  logic [KEY_BITS-1:0]            key,
    input  logic [VALUE_BITS-1:0]          value,
    output logic                           out_valid,
    input  logic                           out_stall,
    output dhoat_pkg::status_t             status,
    output logic [dhoat_pkg::FOUND_W-1:0]  found_value,
    output logic [dhoat_pkg::COUNT_W-1:0]  entry_count
);
    import dhoat_pkg::*;

    localparam int IDX_W  = $clog2(TABLE_SIZE);
    localparam int CNT_W  = $clog2(TABLE_SIZE + 1);
    localparam int DIGITS = (KEY_BITS + 3) / 4;
    localparam int PAD_W  = DIGITS * 4;
    localparam int DCNT_W = $clog2(DIGITS + 1);

    // slot flags {occupied, tombstone}
    localparam logic [1:0] FLAG_EMPTY = 2'b00;
    localparam logic [1:0] FLAG_LIVE  = 2'b10;
    localparam logic [1:0] FLAG_TOMB  = 2'b01;

    // item registers
    action_t               action_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] value_reg;
    logic [PAD_W-1:0]      shift_reg;
    logic [DCNT_W-1:0]     dcnt_reg;

    // hash residues
    logic [IDX_W-1:0]      res_pos;
    logic [IDX_W-1:0]      res_step;

    // probe state
    logic [IDX_W-1:0]      pos_reg;
    logic [IDX_W-1:0]      step_reg;
    logic [IDX_W-1:0]      probe_reg;
    logic [IDX_W-1:0]      target_reg;
    logic                  have_target_reg;
    logic [IDX_W:0]        pos_sum;
    logic [IDX_W-1:0]      pos_next;

    // table state
    logic [CNT_W-1:0]      live_reg;
    logic [IDX_W-1:0]      clr_reg;

    // slot memory
    logic [KEY_BITS-1:0]   mem_key  [TABLE_SIZE];
    logic [VALUE_BITS-1:0] mem_val  [TABLE_SIZE];
    logic [1:0]            mem_flag [TABLE_SIZE];
    logic                  flag_we;
    logic [IDX_W-1:0]      flag_addr;
    logic [1:0]            flag_data;
    logic [1:0]            rd_flag_reg;
    logic [KEY_BITS-1:0]   rd_key_reg;
    logic [VALUE_BITS-1:0] rd_val_reg;

    // output register
    logic                  out_valid_reg;
    status_t               res_status_reg;
    logic [FOUND_W-1:0]    res_found_reg;
    logic [COUNT_W-1:0]    res_count_reg;
    logic [63:0]           val_wide;
    logic [15:0]           live_wide;

    // ---------------- item capture and key digits ----------------
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            action_reg <= action;
            key_reg    <= key;
            value_reg  <= value;
            shift_reg  <= PAD_W'(key);
        end
        else if (cmd.hash_step)
        begin
            shift_reg <= shift_reg << 4;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dcnt_reg <= '0;
        end
        else if (cmd.load)
        begin
            dcnt_reg <= '0;
        end
        else if (cmd.hash_step)
        begin
            dcnt_reg <= dcnt_reg + 1'b1;
        end
    end

    dhoat_hash #(
        .MODULUS (TABLE_SIZE),
        .RES_W   (IDX_W)
    ) u_hash_pos (
        .clk     (clk),
        .clear   (cmd.load),
        .step    (cmd.hash_step),
        .digit   (shift_reg[PAD_W-1 -: 4]),
        .residue (res_pos)
    );

    dhoat_hash #(
        .MODULUS (TABLE_SIZE - 1),
        .RES_W   (IDX_W)
    ) u_hash_step (
        .clk     (clk),
        .clear   (cmd.load),
        .step    (cmd.hash_step),
        .digit   (shift_reg[PAD_W-1 -: 4]),
        .residue (res_step)
    );

    // ---------------- probe sequence ----------------
    // both operands below TABLE_SIZE: one conditional subtract wraps
    always_comb
    begin
        pos_sum = {1'b0, pos_reg} + {1'b0, step_reg};
        if (pos_sum >= (IDX_W + 1)'(TABLE_SIZE))
        begin
            pos_next = IDX_W'(pos_sum - (IDX_W + 1)'(TABLE_SIZE));
        end
        else
        begin
            pos_next = IDX_W'(pos_sum);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.probe_init)
        begin
            pos_reg  <= res_pos;
            step_reg <= res_step + 1'b1;
        end
        else if (cmd.probe_next)
        begin
            pos_reg <= pos_next;
        end
        if (cmd.note_target && !have_target_reg)
        begin
            target_reg <= pos_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_reg       <= '0;
            have_target_reg <= 1'b0;
        end
        else if (cmd.probe_init)
        begin
            probe_reg       <= '0;
            have_target_reg <= 1'b0;
        end
        else
        begin
            if (cmd.probe_next)
            begin
                probe_reg <= probe_reg + 1'b1;
            end
            if (cmd.note_target)
            begin
                have_target_reg <= 1'b1;
            end
        end
    end

    // ---------------- slot memory ----------------
    always_comb
    begin
        flag_we   = cmd.clr_step || cmd.wr_insert || cmd.wr_delete;
        flag_addr = pos_reg;
        flag_data = FLAG_TOMB;
        if (cmd.clr_step)
        begin
            flag_addr = clr_reg;
            flag_data = FLAG_EMPTY;
        end
        else if (cmd.wr_insert)
        begin
            flag_addr = target_reg;
            flag_data = FLAG_LIVE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (flag_we)
        begin
            mem_flag[flag_addr] <= flag_data;
        end
        if (cmd.wr_insert)
        begin
            mem_key[target_reg] <= key_reg;
            mem_val[target_reg] <= value_reg;
        end
        if (cmd.rd)
        begin
            rd_flag_reg <= mem_flag[pos_reg];
            rd_key_reg  <= mem_key[pos_reg];
            rd_val_reg  <= mem_val[pos_reg];
        end
    end

    // ---------------- live count and clear sweep ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg <= '0;
            clr_reg  <= '0;
        end
        else
        begin
            if (cmd.wr_insert)
            begin
                live_reg <= live_reg + 1'b1;
            end
            else if (cmd.wr_delete && (live_reg != '0))
            begin
                live_reg <= live_reg - 1'b1;
            end
            if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
        end
    end

    // ---------------- output register ----------------
    assign val_wide  = 64'(rd_val_reg);
    assign live_wide = 16'(live_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            res_status_reg <= cmd.res_status;
            res_found_reg  <= cmd.res_found ? val_wide[FOUND_W-1:0] : '0;
            res_count_reg  <= live_wide[COUNT_W-1:0];
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = res_status_reg;
    assign found_value = res_found_reg;
    assign entry_count = res_count_reg;

    // ---------------- status to controller ----------------
    always_comb
    begin
        sts.hash_done   = (dcnt_reg == DCNT_W'(DIGITS));
        sts.action      = action_reg;
        sts.full        = (live_reg >= CNT_W'(TABLE_SIZE));
        sts.occ         = rd_flag_reg[1];
        sts.tomb        = rd_flag_reg[0];
        sts.match       = (rd_key_reg == key_reg);
        sts.last_probe  = (probe_reg == IDX_W'(TABLE_SIZE - 1));
        sts.have_target = have_target_reg;
        sts.clr_last    = (clr_reg == IDX_W'(TABLE_SIZE - 1));
        sts.out_free    = !out_valid_reg || !out_stall;
    end

endmodule

### rtl/dhoat_ctrl.sv
// Controller: sequences clear sweep, hashing, probing, writes and result.
// Depends on dhoat_pkg.
module dhoat_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  dhoat_pkg::sts_t sts,
    output dhoat_pkg::cmd_t cmd
);
    import dhoat_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_HASH  = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_CHECK = 3'd4;
    localparam logic [2:0] S_WRITE = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    status_t    status_reg;
    status_t    status_next;
    logic       found_reg;
    logic       found_next;

    always_comb
    begin
        cmd         = '0;
        state_next  = state_reg;
        status_next = status_reg;
        found_next  = found_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                if (!sts.hash_done)
                begin
                    cmd.hash_step = 1'b1;
                end
                else
                begin
                    found_next = 1'b0;
                    if ((sts.action == ACT_INSERT) && sts.full)
                    begin
                        status_next = ST_FULL;
                        state_next  = S_DONE;
                    end
                    else if ((sts.action == ACT_INSERT) || (sts.action == ACT_SEARCH) ||
                             (sts.action == ACT_DELETE))
                    begin
                        cmd.probe_init = 1'b1;
                        state_next     = S_READ;
                    end
                    else
                    begin
                        // unused action code: no change
                        status_next = ST_NOT_FOUND;
                        state_next  = S_DONE;
                    end
                end
            end
            S_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (sts.action == ACT_INSERT)
                begin
                    if (sts.occ && sts.match)
                    begin
                        status_next = ST_DUPLICATE;
                        state_next  = S_DONE;
                    end
                    else if (!sts.occ && !sts.tomb)
                    begin
                        cmd.note_target = 1'b1;
                        state_next      = S_WRITE;
                    end
                    else
                    begin
                        // live other key or tombstone: keep probing for duplicates
                        cmd.note_target = sts.tomb;
                        if (sts.last_probe)
                        begin
                            if (sts.have_target || sts.tomb)
                            begin
                                state_next = S_WRITE;
                            end
                            else
                            begin
                                status_next = ST_FULL;
                                state_next  = S_DONE;
                            end
                        end
                        else
                        begin
                            cmd.probe_next = 1'b1;
                            state_next     = S_READ;
                        end
                    end
                end
                else
                begin
                    if (sts.occ && sts.match)
                    begin
                        status_next = ST_OK;
                        state_next  = S_DONE;
                        if (sts.action == ACT_SEARCH)
                        begin
                            found_next = 1'b1;
                        end
                        else
                        begin
                            cmd.wr_delete = 1'b1;
                        end
                    end
                    else if ((!sts.occ && !sts.tomb) || sts.last_probe)
                    begin
                        status_next = ST_NOT_FOUND;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        cmd.probe_next = 1'b1;
                        state_next     = S_READ;
                    end
                end
            end
            S_WRITE:
            begin
                cmd.wr_insert = 1'b1;
                status_next   = ST_OK;
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = status_reg;
                    cmd.res_found  = found_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            status_reg <= ST_OK;
            found_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
            found_reg  <= found_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

### rtl/double_hash_open_address_table_unit.sv
// Top level of the double-hash open-address key/value table.
// Depends on dhoat_pkg, dhoat_ctrl, dhoat_dp (and dhoat_hash), assert_macros.svh.
//
//  channel | handshake          | payload                             | dir
//  --------+--------------------+-------------------------------------+----
//  in      | in_valid/in_stall  | action, key, value                  | in
//  out     | out_valid/out_stall| status, found_value, entry_count    | out
//
// Sequence: accept, hash (one key digit per step, DIGITS = KEY_BITS/4 rounded up, then a
//   done check that starts the probe), per probe a slot read then a check, a write for an
//   insert, then the output register load. An insert may probe every slot.
// Reset: the controller then clears the slot flags, one per cycle.
// Stalls: a result waits in the output register; the next input transaction is taken
//   meanwhile and holds only at its result load. in_stall is high whenever busy.
`include "assert_macros.svh"

module double_hash_open_address_table_unit #(
    parameter int TABLE_SIZE = dhoat_pkg::TABLE_SIZE_DEF,
    parameter int KEY_BITS   = dhoat_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = dhoat_pkg::VALUE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // input channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  dhoat_pkg::action_t            action,
    input  logic [KEY_BITS-1:0]           key,
    input  logic [VALUE_BITS-1:0]         value,
    // result channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output dhoat_pkg::status_t            status,
    output logic [dhoat_pkg::FOUND_W-1:0] found_value,
    output logic [dhoat_pkg::COUNT_W-1:0] entry_count
);
    import dhoat_pkg::*;

    cmd_t cmd;  // controller commands
    sts_t sts;  // datapath status

    // Controller: clear sweep, hash, probe loop, result hand-off.
    dhoat_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Datapath: residue units, probe arithmetic, slot memory, output register.
    dhoat_dp #(
        .TABLE_SIZE (TABLE_SIZE),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .action      (action),
        .key         (key),
        .value       (value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .found_value (found_value),
        .entry_count (entry_count)
    );

    // An accepted transaction keeps the block busy for at least the hash phase.
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n,
        in_valid && !in_stall, in_stall, "input taken while hashing")

    // The output register is only reloaded when its old result is gone.
    `ASSERT_IMPL(a_load_when_free, clk, rst_n,
        cmd.res_load, sts.out_free, "result overwritten")

    // The slot memory has a single write port.
    `ASSERT_IMPL(a_one_write, clk, rst_n, 1'b1,
        $onehot0({cmd.wr_insert, cmd.wr_delete, cmd.clr_step}), "two slot writes in one cycle")

    // A result appears only after the controller loaded it.
    `ASSERT_IMPL(a_valid_from_load, clk, rst_n,
        $rose(out_valid), $past(cmd.res_load), "result without load")

endmodule
